// ----- hw/rtl/circular_angle_bin_hysteresis_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef CIRCULAR_ANGLE_BIN_HYSTERESIS_CORE_ASSERT_SVH
`define CIRCULAR_ANGLE_BIN_HYSTERESIS_CORE_ASSERT_SVH

// Overlapping implication, sampled on clk_i, off during reset.
`define CABH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CABH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cabh_pkg.sv -----
package cabh_pkg;

  localparam int unsigned MaxFrames = 16;
  localparam int unsigned IdxW      = $clog2(MaxFrames);
  localparam int unsigned AngleW    = 13;
  localparam int unsigned DistW     = 12;
  localparam int unsigned CountW    = 5;

  localparam logic [14:0] FullTurn    = 15'd5760;
  localparam logic [14:0] TwoTurns    = 15'd11520;
  localparam logic [14:0] HalfTurn    = 15'd2880;
  localparam logic [14:0] TurnAndHalf = 15'd8640;
  localparam int unsigned FrameStep   = 360;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_VIEW  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_NUM_FRAMES   = 3'd0,
    CFG_MIRRORING    = 3'd1,
    CFG_ANGLE_OFFSET = 3'd2,
    CFG_HYSTERESIS   = 3'd3,
    CFG_MIN_SPEED    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        operation;
    logic [12:0] view_angle;
    logic [11:0] speed;
    logic [3:0]  entry_index;
    logic [12:0] entry_angle;
  } in_item_t;

  typedef struct packed {
    logic [3:0] frame_index;
    logic       flip;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   addr;
    logic [AngleW-1:0] data;
  } tbl_wr_t;

  // Angle held by an entry that was never written.
  function automatic logic [AngleW-1:0] reset_angle(input logic [IdxW-1:0] idx);
    logic [31:0] prod;
    prod = 32'(idx) * 32'(FrameStep);
    return prod[AngleW-1:0];
  endfunction

  // Circular distance, 0..half turn; a is below a turn, b may be any 13-bit code.
  function automatic logic [DistW-1:0] circ_dist(input logic [AngleW-1:0] a,
                                                 input logic [AngleW-1:0] b);
    logic [14:0] t;
    logic [14:0] m;
    logic [14:0] d;
    t = 15'(a) + TurnAndHalf - 15'(b);
    if (t >= TwoTurns) begin
      m = t - TwoTurns;
    end else if (t >= FullTurn) begin
      m = t - FullTurn;
    end else begin
      m = t;
    end
    d = (m >= HalfTurn) ? (m - HalfTurn) : (HalfTurn - m);
    return d[DistW-1:0];
  endfunction

endpackage

// ----- hw/rtl/cabh_table.sv -----
module cabh_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cabh_pkg::tbl_wr_t              wr_i,
  input  logic [cabh_pkg::IdxW-1:0]      rd_addr_i,
  output logic [cabh_pkg::AngleW-1:0]    rd_data_o
);
  import cabh_pkg::*;

  logic [AngleW-1:0]  mem_q [MaxFrames];
  logic [MaxFrames-1:0] valid_q;
  logic [AngleW-1:0]  rd_q;
  logic               rd_valid_q;
  logic [IdxW-1:0]    rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
      rd_addr_q  <= rd_addr_i;
    end
  end

  // Unwritten entries read as their reset angle.
  assign rd_data_o = rd_valid_q ? rd_q : reset_angle(rd_addr_q);

endmodule

// ----- hw/rtl/circular_angle_bin_hysteresis_core.sv -----
// Sequence: a view sample passes through a prep step, a scan of the N searched
//   entries (N being the entry count), a fetch of the current entry and the load
//   of the output register; the fetch of the current entry is skipped when the
//   current frame lies outside the searched range. A stalled output holds the sample.
// Input: stalled until a view sample is through the output step; a table write or
//   a slow sample is taken without leaving idle. The table has a single read port.
// Reset: table reads back i*360, current frame 0, entry count 16, other config registers 0.
module circular_angle_bin_hysteresis_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [12:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cabh_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cabh_pkg::out_item_t   out_item_o
);
  import cabh_pkg::*;

  // One-hot sequencer: prep computes the angle, scan walks the table,
  // cur fetches the current entry for the hysteresis test, out hands off.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_SCAN = 5'b00100,
    S_CUR  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CountW-1:0]        nframes_q;
  logic                     mirroring_q;
  logic signed [AngleW-1:0] angle_offset_q;
  logic [7:0]               hysteresis_q;
  logic [7:0]               min_speed_q;

  // Working registers of one sample.
  logic [AngleW-1:0] view_q, view_d;
  logic [AngleW-1:0] angle_q, angle_d;
  logic              flip_q, flip_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [DistW-1:0]  best_q, best_d;
  logic [IdxW-1:0]   cand_q, cand_d;
  logic [IdxW-1:0]   cur_q, cur_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // Table port.
  tbl_wr_t           tbl_wr;
  logic [IdxW-1:0]   rd_addr;
  logic [AngleW-1:0] rd_data;

  logic              in_acc;
  logic [CountW-1:0] count_eff;
  logic              last;
  logic signed [14:0] sum;
  logic [14:0]       wrapped;
  logic [DistW-1:0]  entry_gap;
  logic              take;
  logic [IdxW-1:0]   next_cand;
  logic [12:0]       margin;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Config writes; codes outside the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nframes_q      <= CountW'(MaxFrames);
      mirroring_q    <= 1'b0;
      angle_offset_q <= '0;
      hysteresis_q   <= '0;
      min_speed_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_FRAMES:   nframes_q      <= cfg_data_i[CountW-1:0];
        CFG_MIRRORING:    mirroring_q    <= cfg_data_i[0];
        CFG_ANGLE_OFFSET: angle_offset_q <= $signed(cfg_data_i);
        CFG_HYSTERESIS:   hysteresis_q   <= cfg_data_i[7:0];
        CFG_MIN_SPEED:    min_speed_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Clamp the entry count to 1..MaxFrames.
  always_comb begin
    if (nframes_q == '0) begin
      count_eff = CountW'(1);
    end else if (nframes_q > CountW'(MaxFrames)) begin
      count_eff = CountW'(MaxFrames);
    end else begin
      count_eff = nframes_q;
    end
  end

  assign last = ({1'b0, idx_q} == (count_eff - CountW'(1)));

  // View angle plus offset, reduced into one turn.
  always_comb begin
    sum = $signed({2'b00, view_q}) + 15'(angle_offset_q);
    if (sum < 0) begin
      wrapped = 15'(sum) + FullTurn;
    end else if (15'(sum) >= TwoTurns) begin
      wrapped = 15'(sum) - TwoTurns;
    end else if (15'(sum) >= FullTurn) begin
      wrapped = 15'(sum) - FullTurn;
    end else begin
      wrapped = 15'(sum);
    end
  end

  cabh_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign entry_gap = circ_dist(angle_q, rd_data);
  // Strict compare keeps the lowest index on ties.
  assign take      = (idx_q == '0) || (entry_gap < best_q);
  assign next_cand = take ? idx_q : cand_q;
  assign margin    = 13'(best_q) + 13'(hysteresis_q);

  always_comb begin
    state_d     = state_q;
    view_d      = view_q;
    angle_d     = angle_q;
    flip_d      = flip_q;
    idx_d       = idx_q;
    best_d      = best_q;
    cand_d      = cand_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    tbl_wr      = '0;
    rd_addr     = '0;

    // Drop the item once the consumer takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.operation == OP_WRITE) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = in_item_i.entry_index;
            tbl_wr.data = in_item_i.entry_angle;
          end else if (in_item_i.speed >= 12'(min_speed_q)) begin
            view_d  = in_item_i.view_angle;
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        // Reflect above half a turn when mirroring; fetch entry 0.
        if (mirroring_q && (wrapped > HalfTurn)) begin
          angle_d = AngleW'(FullTurn - wrapped);
          flip_d  = 1'b1;
        end else begin
          angle_d = wrapped[AngleW-1:0];
          flip_d  = 1'b0;
        end
        idx_d   = '0;
        rd_addr = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (take) begin
          best_d = entry_gap;
        end
        cand_d = next_cand;
        if (last) begin
          if ({1'b0, cur_q} >= count_eff) begin
            // Current entry outside the searched range: switch at once.
            cur_d   = next_cand;
            state_d = S_OUT;
          end else begin
            rd_addr = cur_q;
            state_d = S_CUR;
          end
        end else begin
          idx_d   = idx_q + IdxW'(1);
          rd_addr = idx_q + IdxW'(1);
        end
      end
      S_CUR: begin
        // Switch only when the nearest entry wins by more than the hysteresis.
        if (margin < 13'(entry_gap)) begin
          cur_d = cand_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_item_d.frame_index = cur_q;
          out_item_d.flip        = flip_q;
          state_d                = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    view_q     <= view_d;
    angle_q    <= angle_d;
    flip_q     <= flip_d;
    idx_q      <= idx_d;
    best_q     <= best_d;
    cand_q     <= cand_d;
    out_item_q <= out_item_d;
  end

endmodule

// ----- hw/rtl/cabh_checker.sv -----
`include "circular_angle_bin_hysteresis_core_assert.svh"

module cabh_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input cabh_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cabh_pkg::out_item_t out_item_o
);
  import cabh_pkg::*;

  logic wr_acc_idle;
  assign wr_acc_idle = in_valid_i && !in_stall_o && !out_valid_o
                       && (in_item_i.operation == OP_WRITE);

  `CABH_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "item dropped")
  `CABH_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_item_o), "item changed")
  `CABH_ASSERT_NEXT(a_write_silent, wr_acc_idle, !out_valid_o, "table write gave an item")
  `CABH_ASSERT_NOW(a_item_from_busy, $rose(out_valid_o), $past(in_stall_o), "item while idle")

endmodule

bind circular_angle_bin_hysteresis_core cabh_checker u_cabh_checker (.*);
